// ----- rtl/glimpse_crop_downsample_defines.svh -----
// Assertion helpers for the glimpse crop block.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef GLIMPSE_CROP_DOWNSAMPLE_DEFINES_SVH
`define GLIMPSE_CROP_DOWNSAMPLE_DEFINES_SVH

// Same-cycle implication.
`define GCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gcd_pkg.sv -----
`default_nettype none

package gcd_pkg;

  localparam int unsigned MaxHeight   = 256;
  localparam int unsigned MaxWidth    = 256;
  localparam int unsigned MaxChannels = 4;
  localparam int unsigned PixelBits   = 16;

  localparam int unsigned RowW  = 8;
  localparam int unsigned ColW  = 8;
  localparam int unsigned ChW   = 2;
  localparam int unsigned FracW = 17;
  localparam int unsigned DimW  = 9;
  localparam int unsigned CropW = 8;
  localparam int unsigned ProdW = FracW + DimW;
  localparam int unsigned SumW  = PixelBits + 2;

  // four banks split by row and column parity
  localparam int unsigned NumBanks  = 4;
  localparam int unsigned BankSelW  = 2;
  localparam int unsigned BankAddrW = ChW + (RowW - 1) + (ColW - 1);
  localparam int unsigned BankDepth = 1 << BankAddrW;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 9;

  localparam logic [FracW-1:0] FracOne = FracW'(65536);

  typedef enum logic {
    OP_STORE   = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_CROP   = 2'd2
  } status_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_CROP_SIZE     = 3'd0,
    CFG_DOWNSAMPLE    = 3'd1,
    CFG_IMAGE_HEIGHT  = 3'd2,
    CFG_IMAGE_WIDTH   = 3'd3,
    CFG_CHANNEL_COUNT = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL_CROP,
    S_MUL_BLOCK,
    S_READ_BLOCK,
    S_SUM
  } state_e;

  typedef struct packed {
    logic                    operation;
    logic [RowW-1:0]         pixel_row;
    logic [ColW-1:0]         pixel_col;
    logic [ChW-1:0]          channel;
    logic signed [PixelBits-1:0] pixel_value;
    logic [FracW-1:0]        loc_row_frac;
    logic [FracW-1:0]        loc_col_frac;
    logic                    use_bounds;
    logic [DimW-1:0]         bound_height;
    logic [DimW-1:0]         bound_width;
    logic [CropW-1:0]        out_row;
    logic [CropW-1:0]        out_col;
  } in_t;

  typedef struct packed {
    logic signed [PixelBits-1:0] crop_value;
    logic signed [PixelBits-1:0] down_value;
    logic [1:0]                  status;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic prep;
    logic mul_crop;
    logic mul_block;
    logic rd_block;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_request;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/gcd_ctrl.sv -----
`default_nettype none

module gcd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire gcd_pkg::sts_t sts_i,
  output gcd_pkg::cmd_t      cmd_o
);

  gcd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gcd_pkg::S_IDLE: begin
        if (in_valid_i && sts_i.is_request) state_d = gcd_pkg::S_PREP;
      end
      gcd_pkg::S_PREP:       state_d = gcd_pkg::S_MUL_CROP;
      gcd_pkg::S_MUL_CROP:   state_d = gcd_pkg::S_MUL_BLOCK;
      gcd_pkg::S_MUL_BLOCK:  state_d = gcd_pkg::S_READ_BLOCK;
      gcd_pkg::S_READ_BLOCK: state_d = gcd_pkg::S_SUM;
      gcd_pkg::S_SUM: begin
        if (!sts_i.out_busy) state_d = gcd_pkg::S_IDLE;
      end
      default: state_d = gcd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      gcd_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      gcd_pkg::S_PREP:       cmd_o.prep      = 1'b1;
      gcd_pkg::S_MUL_CROP:   cmd_o.mul_crop  = 1'b1;
      gcd_pkg::S_MUL_BLOCK:  cmd_o.mul_block = 1'b1;
      gcd_pkg::S_READ_BLOCK: cmd_o.rd_block  = 1'b1;
      gcd_pkg::S_SUM:        cmd_o.load_out  = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/gcd_datapath.sv -----
`default_nettype none

module gcd_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gcd_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [gcd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire gcd_pkg::in_t                  in_data_i,
  input  wire gcd_pkg::cmd_t                 cmd_i,
  output gcd_pkg::sts_t                      sts_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output gcd_pkg::out_t                      out_data_o
);

  localparam int unsigned RowW  = gcd_pkg::RowW;
  localparam int unsigned ColW  = gcd_pkg::ColW;
  localparam int unsigned DimW  = gcd_pkg::DimW;
  localparam int unsigned CropW = gcd_pkg::CropW;
  localparam int unsigned FracW = gcd_pkg::FracW;
  localparam int unsigned ProdW = gcd_pkg::ProdW;
  localparam int unsigned PixW  = gcd_pkg::PixelBits;
  localparam int unsigned SumW  = gcd_pkg::SumW;
  localparam int unsigned AddrW = gcd_pkg::BankAddrW;
  localparam int unsigned SelW  = gcd_pkg::BankSelW;
  localparam int unsigned Banks = gcd_pkg::NumBanks;

  // ---- configuration registers ----
  logic [CropW-1:0]        crop_size_q;
  logic                    ds_en_q;
  logic [DimW-1:0]         img_h_q, img_w_q;
  logic [2:0]              ch_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crop_size_q <= CropW'(1);
      ds_en_q     <= 1'b0;
      img_h_q     <= DimW'(gcd_pkg::MaxHeight);
      img_w_q     <= DimW'(gcd_pkg::MaxWidth);
      ch_cnt_q    <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (gcd_pkg::cfg_idx_e'(cfg_addr_i))
        gcd_pkg::CFG_CROP_SIZE:     crop_size_q <= cfg_wdata_i[CropW-1:0];
        gcd_pkg::CFG_DOWNSAMPLE:    ds_en_q     <= cfg_wdata_i[0];
        gcd_pkg::CFG_IMAGE_HEIGHT:  img_h_q     <= cfg_wdata_i;
        gcd_pkg::CFG_IMAGE_WIDTH:   img_w_q     <= cfg_wdata_i;
        gcd_pkg::CFG_CHANNEL_COUNT: ch_cnt_q    <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // ---- request capture ----
  gcd_pkg::in_t req_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (in_data_i.operation == gcd_pkg::OP_REQUEST)) req_q <= in_data_i;
  end

  // ---- prep: clamp, pick bounds, check ----
  logic [DimW-1:0]  ih, iw, h, w, c9, c2;
  logic [CropW-1:0] c, c_m1, orr, occ;
  logic [FracW-1:0] fr, fc;
  logic             bounds_err, crop_err, ch_used;
  gcd_pkg::status_e status;

  always_comb begin
    ih   = (img_h_q > DimW'(gcd_pkg::MaxHeight)) ? DimW'(gcd_pkg::MaxHeight) : img_h_q;
    iw   = (img_w_q > DimW'(gcd_pkg::MaxWidth)) ? DimW'(gcd_pkg::MaxWidth) : img_w_q;
    c    = (crop_size_q == '0) ? CropW'(1) : crop_size_q;
    c_m1 = c - CropW'(1);
    c9   = {1'b0, c};
    c2   = {c, 1'b0};
    fr   = (req_q.loc_row_frac > gcd_pkg::FracOne) ? gcd_pkg::FracOne : req_q.loc_row_frac;
    fc   = (req_q.loc_col_frac > gcd_pkg::FracOne) ? gcd_pkg::FracOne : req_q.loc_col_frac;
    orr  = (req_q.out_row > c_m1) ? c_m1 : req_q.out_row;
    occ  = (req_q.out_col > c_m1) ? c_m1 : req_q.out_col;
    h    = req_q.use_bounds ? req_q.bound_height : ih;
    w    = req_q.use_bounds ? req_q.bound_width  : iw;
    bounds_err = req_q.use_bounds && ((req_q.bound_height > ih) || (req_q.bound_width > iw));
    crop_err   = (c9 > h) || (c9 > w) || (ds_en_q && ((c2 > h) || (c2 > w)));
    if (bounds_err)      status = gcd_pkg::ST_BOUNDS;
    else if (crop_err)   status = gcd_pkg::ST_CROP;
    else                 status = gcd_pkg::ST_OK;
    ch_used = ({1'b0, req_q.channel} < ch_cnt_q);
  end

  logic [FracW-1:0] fr_q, fc_q;
  logic [CropW-1:0] orr_q, occ_q;
  logic [DimW-1:0]  room_r1_q, room_c1_q, room_r2_q, room_c2_q;
  gcd_pkg::status_e status_q;
  logic             active_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      fr_q      <= fr;
      fc_q      <= fc;
      orr_q     <= orr;
      occ_q     <= occ;
      room_r1_q <= h - c9;
      room_c1_q <= w - c9;
      room_r2_q <= h - c2;   // meaningful only when the doubled crop fits
      room_c2_q <= w - c2;
      status_q  <= status;
      active_q  <= (status == gcd_pkg::ST_OK) && ch_used;
    end
  end

  // ---- origin: one multiplier pair shared by plain and doubled crop ----
  logic [DimW-1:0]  room_r, room_c, off_r, off_c, pos_r, pos_c;
  logic [ProdW-1:0] prod_r, prod_c;

  always_comb begin
    room_r = cmd_i.mul_block ? room_r2_q : room_r1_q;
    room_c = cmd_i.mul_block ? room_c2_q : room_c1_q;
    off_r  = cmd_i.mul_block ? {orr_q, 1'b0} : {1'b0, orr_q};
    off_c  = cmd_i.mul_block ? {occ_q, 1'b0} : {1'b0, occ_q};
    prod_r = {{DimW{1'b0}}, fr_q} * {{FracW{1'b0}}, room_r};
    prod_c = {{DimW{1'b0}}, fc_q} * {{FracW{1'b0}}, room_c};
    pos_r  = {1'b0, prod_r[16 +: RowW]} + off_r;
    pos_c  = {1'b0, prod_c[16 +: ColW]} + off_c;
  end

  logic [RowW-1:0] r0_q, r1_q;
  logic [ColW-1:0] c0_q, c1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_crop) begin
      r0_q <= pos_r[RowW-1:0];
      c0_q <= pos_c[ColW-1:0];
    end
    if (cmd_i.mul_block) begin
      r1_q <= pos_r[RowW-1:0];
      c1_q <= pos_c[ColW-1:0];
    end
  end

  // ---- image banks ----
  // bank = {row parity, col parity}; a 2x2 block touches each bank once
  logic [SelW-1:0]            wr_bank, crop_bank;
  logic [AddrW-1:0]           wr_addr, crop_addr;
  logic                       store_fire;
  logic [RowW-1:0]            r1_p1;
  logic [ColW-1:0]            c1_p1;
  logic [Banks-1:0]           rd_en;
  logic [Banks-1:0][AddrW-1:0] rd_addr;
  logic [Banks-1:0][PixW-1:0] rd_q;

  assign store_fire = cmd_i.accept && (in_data_i.operation == gcd_pkg::OP_STORE);
  assign wr_bank    = {in_data_i.pixel_row[0], in_data_i.pixel_col[0]};
  assign wr_addr    = {in_data_i.channel, in_data_i.pixel_row[RowW-1:1],
                       in_data_i.pixel_col[ColW-1:1]};
  assign crop_bank  = {r0_q[0], c0_q[0]};
  assign crop_addr  = {req_q.channel, r0_q[RowW-1:1], c0_q[ColW-1:1]};
  assign r1_p1      = r1_q + RowW'(1);
  assign c1_p1      = c1_q + ColW'(1);

  for (genvar b = 0; b < Banks; b++) begin : g_bank
    localparam logic [SelW-1:0] BankId = SelW'(b);
    logic [PixW-1:0]  mem [gcd_pkg::BankDepth];
    logic [RowW-1:0]  blk_row;
    logic [ColW-1:0]  blk_col;

    assign blk_row = (r1_q[0] == BankId[1]) ? r1_q : r1_p1;
    assign blk_col = (c1_q[0] == BankId[0]) ? c1_q : c1_p1;
    assign rd_en[b] = cmd_i.rd_block || (cmd_i.mul_block && (crop_bank == BankId));
    assign rd_addr[b] = cmd_i.rd_block
                      ? {req_q.channel, blk_row[RowW-1:1], blk_col[ColW-1:1]}
                      : crop_addr;

    always_ff @(posedge clk_i) begin
      if (store_fire && (wr_bank == BankId)) mem[wr_addr] <= in_data_i.pixel_value;
    end

    always_ff @(posedge clk_i) begin
      if (rd_en[b]) rd_q[b] <= mem[rd_addr[b]];
    end
  end

  // crop pixel lands during the block read cycle
  logic [PixW-1:0] crop_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_block) crop_q <= rd_q[crop_bank];
  end

  // ---- 2x2 floor average: arithmetic shift of the 18-bit sum ----
  logic [SumW-1:0] blk_sum;

  always_comb begin
    blk_sum = '0;
    for (int i = 0; i < Banks; i++) begin
      blk_sum = blk_sum + {{(SumW-PixW){rd_q[i][PixW-1]}}, rd_q[i]};
    end
  end

  // ---- output register ----
  logic          out_valid_q;
  gcd_pkg::out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.crop_value <= active_q ? crop_q : '0;
      out_q.down_value <= (active_q && ds_en_q) ? blk_sum[SumW-1:2] : '0;
      out_q.status     <= status_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;
  assign sts_o.is_request = (in_data_i.operation == gcd_pkg::OP_REQUEST);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

// ----- rtl/glimpse_crop_downsample.sv -----
// Pixel store: one transfer per cycle while the controller is idle, no result, written at the accepting edge.
// Crop request: the result is registered after these steps, and no new transfer is taken
// until they finish: the idle accept, prep, two shared multiply steps (the second also reads the
// crop pixel), the block read and the sum. A full output register that is not taken
// holds the controller in its last step.
// Reset (rst_ni low, async): controller idle, output empty, config to its defaults.
`default_nettype none
`include "glimpse_crop_downsample_defines.svh"

module glimpse_crop_downsample (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [gcd_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [gcd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input items: stores and requests
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire gcd_pkg::in_t                  in_data_i,
  // results, one per request
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output gcd_pkg::out_t                      out_data_o
);

  // Command/status link between the sequencer and the datapath.
  gcd_pkg::cmd_t cmd;
  gcd_pkg::sts_t sts;

  // Sequencer: idle accepts any transfer; a request then steps through
  //   prep      - clamp fraction/element, choose bounds, error status
  //   mul crop  - origin of the plain crop (frac * room >> 16 + element)
  //   mul block - origin of the doubled crop, read the crop pixel
  //   read blk  - read the 2x2 block, one pixel from each parity bank
  //   sum       - floor average, load the output register when free
  // The image banks are not cleared; pixels read before being stored are undefined.
  gcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: config registers, four parity banks holding the image,
  // the shared origin multipliers and the output register.
  gcd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // terms for the checks below
  logic req_fire, err_out, vals_zero;

  assign req_fire  = cmd.accept && (in_data_i.operation == gcd_pkg::OP_REQUEST);
  assign err_out   = out_valid_o && (out_data_o.status != gcd_pkg::ST_OK);
  assign vals_zero = (out_data_o.crop_value == '0) && (out_data_o.down_value == '0);

  // a request transfer takes the sequencer out of idle
  `GCD_ASSERT_NEXT(a_req_leaves_idle, req_fire, !in_ready_o, "request did not start")
  // a load always shows up on the output
  `GCD_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid_o, "loaded result not presented")
  // error results carry zero values
  `GCD_ASSERT_SAME(a_err_zero, err_out, vals_zero, "error result with nonzero values")

endmodule

`default_nettype wire
